[sv/pewr_pkg.sv]
// Shared types, codes and constants of the period extremes and window range core.
// Used by every module of the block; depends on nothing else.
package pewr_pkg;

    // Default values of the top-level parameters.
    localparam int TOP_COUNT_DEF         = 5;
    localparam int MAX_WINDOW_GROUPS_DEF = 16;
    localparam int SAMPLE_BITS_DEF       = 12;

    // Fixed widths of the result fields.
    localparam int RANK_BITS  = 3;
    localparam int VAL_BITS   = 12;
    localparam int RANGE_BITS = 12;
    localparam int OUT_FIELD_BITS = RANK_BITS + 2 * VAL_BITS + RANGE_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // Largest range that the result field can carry.
    localparam logic [RANGE_BITS-1:0] RANGE_MAX = {RANGE_BITS{1'b1}};

    // Configuration registers.
    localparam int SPG_BITS       = 4;
    localparam int WG_BITS        = 5;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 5;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLES_PER_GROUP = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_GROUPS     = 2'd1;

    localparam logic [SPG_BITS-1:0] SPG_RESET = 4'd8;
    localparam logic [SPG_BITS-1:0] SPG_MAX   = 4'd8;
    localparam logic [WG_BITS-1:0]  WG_RESET  = 5'd10;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT
    } t_state;

    // Commands to the extreme lists.
    typedef struct packed {
        logic take;   // insert the accepted sample
        logic shift;  // move the lists one place towards the head
        logic clear;  // forget all kept samples
    } t_topk_ctl;

    // Commands to the minute ring and window unit.
    typedef struct packed {
        logic take;   // account the accepted sample
        logic clear;  // start a new period
    } t_win_ctl;

endpackage

[sv/period_extremes_and_window_range_core.sv]
// Period extremes and window range core: takes one signed temperature word per
// handshake, keeps the TOP_COUNT lowest and highest samples of the period and,
// after every finished minute, the largest max-minus-min over the last
// window_groups minutes. A word marked with tlast ends the period: it is
// accounted first, then TOP_COUNT result words follow, most extreme first, the
// last one flagged by tlast, and all period state is cleared. After an input word
// is taken, the block waits until any window walk is over; a walk runs when the
// word closes a minute with enough minutes in the ring and goes over the minute
// ring memory, which has one read port and delivers one minute per cycle.
// Results go out one per cycle while the sink is ready; no input is taken
// during a walk or a report. Configuration is written on its own channel.
module period_extremes_and_window_range_core import pewr_pkg::*; #(
    parameter int TOP_COUNT         = TOP_COUNT_DEF,
    parameter int MAX_WINDOW_GROUPS = MAX_WINDOW_GROUPS_DEF,
    parameter int SAMPLE_BITS       = SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input words.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,  // sample
    input  logic                              s_axis_tlast,  // period_end
    // Result words.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // rank, lowest_value, highest_value, largest_range, zero padding
    output logic [OUT_TDATA_BITS-1:0]         m_axis_tdata,
    output logic                              m_axis_tuser,  // entry_valid
    output logic                              m_axis_tlast,  // last_result
    // Configuration writes.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]         i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]          i_cfg_data
);

    localparam int KW = $clog2(TOP_COUNT + 1);
    localparam int RW = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
    localparam int CW = (SAMPLE_BITS > VAL_BITS) ? SAMPLE_BITS : VAL_BITS;
    localparam int OUT_PAD = OUT_TDATA_BITS - OUT_FIELD_BITS;

    t_state                        r_state;
    t_state                        n_state;
    logic [SPG_BITS-1:0]           r_spg;
    logic [WG_BITS-1:0]            r_wg;
    logic                          r_end;
    logic [RW-1:0]                 r_rank;

    logic                          w_in_acc;
    logic                          w_out_acc;
    logic                          w_last;
    logic                          w_busy;
    logic signed [SAMPLE_BITS-1:0] w_sample;
    logic [KW-1:0]                 w_kept;
    logic signed [SAMPLE_BITS-1:0] w_low_head;
    logic signed [SAMPLE_BITS-1:0] w_high_head;
    logic [RANGE_BITS-1:0]         w_best;
    logic                          w_entry_valid;
    logic signed [CW-1:0]          w_low_ext;
    logic signed [CW-1:0]          w_high_ext;
    logic [VAL_BITS-1:0]           w_low_val;
    logic [VAL_BITS-1:0]           w_high_val;
    t_topk_ctl                     w_topk_ctl;
    t_win_ctl                      w_win_ctl;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;
    assign w_last    = (r_rank == RW'(TOP_COUNT - 1));
    assign w_sample  = s_axis_tdata[SAMPLE_BITS-1:0];

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spg <= SPG_RESET;
            r_wg  <= WG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SAMPLES_PER_GROUP: r_spg <= i_cfg_data[SPG_BITS-1:0];
                REG_WINDOW_GROUPS:     r_wg  <= i_cfg_data[WG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer: take a word, let the window walk finish, report if the
    // period has ended.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (!w_busy) begin
                    n_state = r_end ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (w_out_acc && w_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Handshake outputs of the sequencer.
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_WALK: ;
            ST_EMIT: m_axis_tvalid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_end   <= 1'b0;
            r_rank  <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_end <= s_axis_tlast;
            end
            if (w_out_acc) begin
                r_rank <= w_last ? '0 : r_rank + 1'b1;
            end
        end
    end

    // Commands to the two units.
    always_comb begin
        w_topk_ctl.take  = w_in_acc;
        w_topk_ctl.shift = w_out_acc;
        w_topk_ctl.clear = w_out_acc && w_last;
        w_win_ctl.take   = w_in_acc;
        w_win_ctl.clear  = w_out_acc && w_last;
    end

    pewr_topk #(
        .TOP_COUNT   (TOP_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_topk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_topk_ctl),
        .i_sample     (w_sample),
        .o_kept_count (w_kept),
        .o_low_head   (w_low_head),
        .o_high_head  (w_high_head)
    );

    pewr_window #(
        .MAX_WINDOW_GROUPS (MAX_WINDOW_GROUPS),
        .SAMPLE_BITS       (SAMPLE_BITS)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_win_ctl),
        .i_sample     (w_sample),
        .i_spg        (r_spg),
        .i_wg         (r_wg),
        .o_busy       (w_busy),
        .o_best_range (w_best)
    );

    // Result word: the list heads are shifted out one rank per word, and a
    // rank beyond the fill count reports zero values.
    assign w_entry_valid = (KW'(r_rank) < w_kept);
    assign w_low_ext     = CW'(w_low_head);
    assign w_high_ext    = CW'(w_high_head);
    assign w_low_val     = w_entry_valid ? w_low_ext[VAL_BITS-1:0]  : '0;
    assign w_high_val    = w_entry_valid ? w_high_ext[VAL_BITS-1:0] : '0;

    assign m_axis_tdata = {{OUT_PAD{1'b0}}, w_best, w_high_val, w_low_val,
                           RANK_BITS'(r_rank)};
    assign m_axis_tuser = w_entry_valid;
    assign m_axis_tlast = w_last;

endmodule

[sv/pewr_topk.sv]
// Sorted lists of the lowest and highest samples of a period.
// Depends on pewr_pkg for the command struct.
module pewr_topk import pewr_pkg::*; #(
    parameter int TOP_COUNT   = TOP_COUNT_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  t_topk_ctl                             i_ctl,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample,
    output logic [$clog2(TOP_COUNT+1)-1:0]        o_kept_count,
    output logic signed [SAMPLE_BITS-1:0]         o_low_head,
    output logic signed [SAMPLE_BITS-1:0]         o_high_head
);

    localparam int KW = $clog2(TOP_COUNT + 1);

    logic signed [SAMPLE_BITS-1:0] r_low  [TOP_COUNT];
    logic signed [SAMPLE_BITS-1:0] r_high [TOP_COUNT];
    logic signed [SAMPLE_BITS-1:0] n_low  [TOP_COUNT];
    logic signed [SAMPLE_BITS-1:0] n_high [TOP_COUNT];
    logic [KW-1:0]                 r_kept;
    logic [KW-1:0]                 n_kept;
    logic [TOP_COUNT-1:0]          w_go_low;
    logic [TOP_COUNT-1:0]          w_go_high;

    // A place takes part in the insertion when it is empty or the new sample
    // ranks strictly before its entry; equal samples keep their order.
    always_comb begin
        for (int p = 0; p < TOP_COUNT; p++) begin
            w_go_low[p]  = (KW'(p) >= r_kept) || (i_sample < r_low[p]);
            w_go_high[p] = (KW'(p) >= r_kept) || (i_sample > r_high[p]);
        end
    end

    // Each place either keeps its entry, takes the new sample or takes its
    // neighbour's entry; the worst entry of a full list falls off the end.
    for (genvar g = 0; g < TOP_COUNT; g++) begin : g_place
        logic signed [SAMPLE_BITS-1:0] w_ins_low;
        logic signed [SAMPLE_BITS-1:0] w_ins_high;
        logic signed [SAMPLE_BITS-1:0] w_next_low;
        logic signed [SAMPLE_BITS-1:0] w_next_high;

        if (g == 0) begin : g_head
            assign w_ins_low  = i_sample;
            assign w_ins_high = i_sample;
        end else begin : g_body
            assign w_ins_low  = w_go_low[g-1]  ? r_low[g-1]  : i_sample;
            assign w_ins_high = w_go_high[g-1] ? r_high[g-1] : i_sample;
        end

        if (g == TOP_COUNT - 1) begin : g_tail
            assign w_next_low  = r_low[g];
            assign w_next_high = r_high[g];
        end else begin : g_inner
            assign w_next_low  = r_low[g+1];
            assign w_next_high = r_high[g+1];
        end

        always_comb begin
            n_low[g]  = r_low[g];
            n_high[g] = r_high[g];
            if (i_ctl.take) begin
                if (w_go_low[g]) begin
                    n_low[g] = w_ins_low;
                end
                if (w_go_high[g]) begin
                    n_high[g] = w_ins_high;
                end
            end else if (i_ctl.shift) begin
                n_low[g]  = w_next_low;
                n_high[g] = w_next_high;
            end
        end
    end

    // List entries hold payload only; the fill count says which are valid.
    always_ff @(posedge i_clk) begin
        for (int p = 0; p < TOP_COUNT; p++) begin
            r_low[p]  <= n_low[p];
            r_high[p] <= n_high[p];
        end
    end

    // Fill count, saturating at the list depth.
    always_comb begin
        n_kept = r_kept;
        if (i_ctl.clear) begin
            n_kept = '0;
        end else if (i_ctl.take && (r_kept < KW'(TOP_COUNT))) begin
            n_kept = r_kept + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept <= '0;
        end else begin
            r_kept <= n_kept;
        end
    end

    assign o_kept_count = r_kept;
    assign o_low_head   = r_low[0];
    assign o_high_head  = r_high[0];

endmodule

[sv/pewr_window.sv]
// Per-minute extremes, the ring memory of finished minutes and the window walk
// that tracks the largest range. Depends on pewr_pkg.
module pewr_window import pewr_pkg::*; #(
    parameter int MAX_WINDOW_GROUPS = MAX_WINDOW_GROUPS_DEF,
    parameter int SAMPLE_BITS       = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_win_ctl                      i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [SPG_BITS-1:0]           i_spg,
    input  logic [WG_BITS-1:0]            i_wg,
    output logic                          o_busy,
    output logic [RANGE_BITS-1:0]         o_best_range
);

    localparam int PW = $clog2(MAX_WINDOW_GROUPS);
    localparam int FW = $clog2(MAX_WINDOW_GROUPS + 1);
    localparam int CW = (SAMPLE_BITS + 1 > RANGE_BITS) ? SAMPLE_BITS + 1 : RANGE_BITS;
    localparam int DW = CW + 1;

    localparam logic signed [SAMPLE_BITS-1:0] MOST_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [PW-1:0] LAST_SLOT = PW'(MAX_WINDOW_GROUPS - 1);

    // Ring memory, one word per finished minute: maximum above minimum.
    logic [2*SAMPLE_BITS-1:0] mem [MAX_WINDOW_GROUPS];
    logic [2*SAMPLE_BITS-1:0] r_rd_data;

    logic signed [SAMPLE_BITS-1:0] r_cur_min;
    logic signed [SAMPLE_BITS-1:0] r_cur_max;
    logic [2:0]                    r_in_count;
    logic [FW-1:0]                 r_filled;
    logic [PW-1:0]                 r_ptr;
    logic [RANGE_BITS-1:0]         r_best;

    logic [FW-1:0]                 r_rd_left;
    logic                          r_rd_pend;
    logic                          r_fin;
    logic [PW-1:0]                 r_rd_addr;
    logic signed [SAMPLE_BITS-1:0] r_lo;
    logic signed [SAMPLE_BITS-1:0] r_hi;

    logic [SPG_BITS-1:0]           w_spg_eff;
    logic [FW-1:0]                 w_wg_eff;
    logic signed [SAMPLE_BITS-1:0] w_min_new;
    logic signed [SAMPLE_BITS-1:0] w_max_new;
    logic [SPG_BITS-1:0]           w_count_inc;
    logic                          w_close;
    logic [PW-1:0]                 w_ptr_next;
    logic [FW-1:0]                 w_filled_next;
    logic                          w_start;
    logic                          w_rd_en;
    logic signed [SAMPLE_BITS-1:0] w_rd_min;
    logic signed [SAMPLE_BITS-1:0] w_rd_max;
    logic signed [DW-1:0]          w_diff;
    logic [RANGE_BITS-1:0]         w_range;

    // Register values outside their useful span are clamped.
    always_comb begin
        if (i_spg == '0) begin
            w_spg_eff = SPG_BITS'(1);
        end else if (i_spg > SPG_MAX) begin
            w_spg_eff = SPG_MAX;
        end else begin
            w_spg_eff = i_spg;
        end

        if (i_wg == '0) begin
            w_wg_eff = FW'(1);
        end else if (int'(i_wg) > MAX_WINDOW_GROUPS) begin
            w_wg_eff = FW'(MAX_WINDOW_GROUPS);
        end else begin
            w_wg_eff = FW'(i_wg);
        end
    end

    // Minute bookkeeping for the accepted sample.
    assign w_min_new   = (i_sample < r_cur_min) ? i_sample : r_cur_min;
    assign w_max_new   = (i_sample > r_cur_max) ? i_sample : r_cur_max;
    assign w_count_inc = SPG_BITS'(r_in_count) + 1'b1;
    assign w_close     = i_ctl.take && (w_count_inc >= w_spg_eff);
    assign w_ptr_next  = (r_ptr == LAST_SLOT) ? '0 : r_ptr + 1'b1;
    assign w_filled_next = (r_filled == FW'(MAX_WINDOW_GROUPS)) ? r_filled
                                                                : r_filled + 1'b1;
    assign w_start     = w_close && (w_filled_next >= w_wg_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_min  <= MOST_POS;
            r_cur_max  <= MOST_NEG;
            r_in_count <= '0;
            r_filled   <= '0;
            r_ptr      <= '0;
        end else if (i_ctl.clear) begin
            r_cur_min  <= MOST_POS;
            r_cur_max  <= MOST_NEG;
            r_in_count <= '0;
            r_filled   <= '0;
            r_ptr      <= '0;
        end else if (w_close) begin
            r_cur_min  <= MOST_POS;
            r_cur_max  <= MOST_NEG;
            r_in_count <= '0;
            r_filled   <= w_filled_next;
            r_ptr      <= w_ptr_next;
        end else if (i_ctl.take) begin
            r_cur_min  <= w_min_new;
            r_cur_max  <= w_max_new;
            r_in_count <= w_count_inc[2:0];
        end
    end

    // The ring is written only when a sample is taken, and the sequencer takes
    // no sample while a walk is running, so a write and a read never meet.
    assign w_rd_en = (r_rd_left != '0);

    always_ff @(posedge i_clk) begin
        if (w_close) begin
            mem[r_ptr] <= {w_max_new, w_min_new};
        end
        if (w_rd_en) begin
            r_rd_data <= mem[r_rd_addr];
        end
    end

    // Walk control: one read a cycle, newest minute first; once the last read
    // data is folded in, r_fin turns the window bounds into a range.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_left <= '0;
            r_rd_pend <= 1'b0;
            r_fin     <= 1'b0;
        end else begin
            if (w_start) begin
                r_rd_left <= w_wg_eff;
            end else if (w_rd_en) begin
                r_rd_left <= r_rd_left - 1'b1;
            end
            r_rd_pend <= w_rd_en;
            r_fin     <= r_rd_pend && !w_rd_en;
        end
    end

    assign w_rd_min = r_rd_data[SAMPLE_BITS-1:0];
    assign w_rd_max = r_rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];

    // Walk address and running window bounds.
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_rd_addr <= r_ptr;
            r_lo      <= MOST_POS;
            r_hi      <= MOST_NEG;
        end else begin
            if (w_rd_en) begin
                r_rd_addr <= (r_rd_addr == '0) ? LAST_SLOT : r_rd_addr - 1'b1;
            end
            if (r_rd_pend) begin
                if (w_rd_min < r_lo) begin
                    r_lo <= w_rd_min;
                end
                if (w_rd_max > r_hi) begin
                    r_hi <= w_rd_max;
                end
            end
        end
    end

    // Window range, saturated to the result field, and the running best.
    assign w_diff  = DW'(r_hi) - DW'(r_lo);
    assign w_range = (w_diff > DW'(RANGE_MAX)) ? RANGE_MAX : w_diff[RANGE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '0;
        end else if (i_ctl.clear) begin
            r_best <= '0;
        end else if (r_fin && (w_range > r_best)) begin
            r_best <= w_range;
        end
    end

    assign o_busy       = w_rd_en || r_rd_pend || r_fin;
    assign o_best_range = r_best;

endmodule

[sv/pewr_checker.sv]
// Port-level checks of the period extremes and window range core, bound to it.
// Depends on pewr_pkg and on the top level's port list.
module pewr_checker import pewr_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
    input logic                      m_axis_tuser,
    input logic                      m_axis_tlast
);

    // The block never takes a word while it reports.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result word is offered");

    // Each accepted word is worked on before the next one is taken.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready straight after an accepted word");

    // A report runs without gaps until its last word.
    a_report_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("report stopped before its last word");

    // After the last word of a report the block is idle again.
    a_report_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (!m_axis_tvalid && s_axis_tready))
        else $error("block not idle after the last result word");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("stalled result word changed");

endmodule

bind period_extremes_and_window_range_core pewr_checker u_pewr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

[tb/pewr_report_checker.sv]
`timescale 1ns / 1ps
// Report checker for the period extremes and window range core: watches the input, result and
// configuration channels, predicts every report word and compares it field by field.
// Depends on pewr_pkg for widths, register indexes and reset values.
module pewr_report_checker import pewr_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Input channel of the block.
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [((SAMPLE_BITS_DEF+7)/8)*8-1:0] i_in_data,  // sample
    input  logic                      i_in_last,              // period_end
    // Result channel of the block.
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    // rank, lowest_value, highest_value, largest_range, zero padding
    input  logic [OUT_TDATA_BITS-1:0] i_out_data,
    input  logic                      i_out_user,             // entry_valid
    input  logic                      i_out_last,             // last_result
    // Configuration channel of the block.
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    // Status towards the testbench top.
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_reports
);

    localparam int KEEP        = TOP_COUNT_DEF;
    localparam int RING        = MAX_WINDOW_GROUPS_DEF;
    localparam int SBITS       = SAMPLE_BITS_DEF;
    localparam int READING_MAX = 2 ** (SBITS - 1) - 1;
    localparam int READING_MIN = -READING_MAX - 1;

    typedef int t_list [KEEP];

    typedef struct {
        logic [RANK_BITS-1:0]       rank;
        logic                       entry_valid;
        logic signed [VAL_BITS-1:0] lowest;
        logic signed [VAL_BITS-1:0] highest;
        logic [RANGE_BITS-1:0]      wide_range;
        logic                       last_row;
    } t_report_row;

    // Report words still owed by the block, oldest first.
    t_report_row awaited_rows[$];

    // Own copy of the period state and the registers.
    t_list               lows;
    t_list               highs;
    int                  kept;
    int                  minute_min [RING];
    int                  minute_max [RING];
    int                  cur_min;
    int                  cur_max;
    int                  in_minute;
    int                  minutes_held;
    int                  ring_ptr;
    int                  best_spread;
    logic [SPG_BITS-1:0] spg_reg;
    logic [WG_BITS-1:0]  wg_reg;
    int                  errors  = 0;
    int                  reports = 0;

    function automatic void clear_period();
        kept         = 0;
        cur_min      = READING_MAX;
        cur_max      = READING_MIN;
        in_minute    = 0;
        minutes_held = 0;
        ring_ptr     = 0;
        best_spread  = 0;
    endfunction

    // Places a reading in a ranked list, most extreme first; ties take their own rank.
    function automatic t_list ranked_insert(t_list list, int n, int v, bit want_low);
        int pos;
        if (n >= KEEP) begin
            if (want_low ? (v >= list[KEEP-1]) : (v <= list[KEEP-1]))
                return list;
            n = KEEP - 1;
        end
        pos = n;
        while (pos > 0 && (want_low ? v < list[pos-1] : v > list[pos-1])) begin
            list[pos] = list[pos-1];
            pos--;
        end
        list[pos] = v;
        return list;
    endfunction

    // Pushes the finished minute into the ring and scores the newest window.
    function automatic void close_minute();
        int win;
        int lo;
        int hi;
        int idx;
        minute_min[ring_ptr] = cur_min;
        minute_max[ring_ptr] = cur_max;
        ring_ptr = (ring_ptr + 1) % RING;
        if (minutes_held < RING)
            minutes_held++;
        cur_min   = READING_MAX;
        cur_max   = READING_MIN;
        in_minute = 0;

        win = int'(wg_reg);
        if (win == 0)
            win = 1;
        if (win > RING)
            win = RING;
        if (minutes_held < win)
            return;

        lo = READING_MAX;
        hi = READING_MIN;
        for (int i = 1; i <= win; i++) begin
            idx = (ring_ptr + RING - i) % RING;
            if (minute_min[idx] < lo)
                lo = minute_min[idx];
            if (minute_max[idx] > hi)
                hi = minute_max[idx];
        end
        if (hi - lo > int'(RANGE_MAX))
            hi = lo + int'(RANGE_MAX);
        if (hi - lo > best_spread)
            best_spread = hi - lo;
    endfunction

    // Accounts one accepted input word; a period end queues the whole report.
    function automatic void account_reading(logic [SBITS-1:0] raw, logic period_end);
        int          v;
        int          per_minute;
        t_report_row row;
        v = int'($signed(raw));
        per_minute = int'(spg_reg);
        if (per_minute == 0)
            per_minute = 1;
        if (per_minute > int'(SPG_MAX))
            per_minute = int'(SPG_MAX);

        lows  = ranked_insert(lows, kept, v, 1'b1);
        highs = ranked_insert(highs, kept, v, 1'b0);
        if (kept < KEEP)
            kept++;

        if (v < cur_min)
            cur_min = v;
        if (v > cur_max)
            cur_max = v;
        in_minute++;
        if (in_minute >= per_minute)
            close_minute();

        if (!period_end)
            return;

        for (int k = 0; k < KEEP; k++) begin
            row.rank        = k[RANK_BITS-1:0];
            row.entry_valid = (k < kept);
            row.lowest      = (k < kept) ? lows[k][VAL_BITS-1:0] : '0;
            row.highest     = (k < kept) ? highs[k][VAL_BITS-1:0] : '0;
            row.wide_range  = best_spread[RANGE_BITS-1:0];
            row.last_row    = (k == KEEP - 1);
            awaited_rows.insert(awaited_rows.size(), row);
        end
        reports++;
        clear_period();
    endfunction

    // Compares one accepted result word with the oldest expectation.
    function automatic void check_row();
        t_report_row                want;
        logic [RANK_BITS-1:0]       got_rank;
        logic signed [VAL_BITS-1:0] got_low;
        logic signed [VAL_BITS-1:0] got_high;
        logic [RANGE_BITS-1:0]      got_range;
        got_rank  = i_out_data[RANK_BITS-1:0];
        got_low   = i_out_data[RANK_BITS +: VAL_BITS];
        got_high  = i_out_data[RANK_BITS+VAL_BITS +: VAL_BITS];
        got_range = i_out_data[RANK_BITS+2*VAL_BITS +: RANGE_BITS];
        if (awaited_rows.size() == 0) begin
            $error("result word with no report pending: tdata %h", i_out_data);
            errors++;
            return;
        end
        want = awaited_rows[0];
        awaited_rows.delete(0);
        if (got_rank !== want.rank) begin
            $error("rank: expected %0d, actual %0d", want.rank, got_rank);
            errors++;
        end
        if (i_out_user !== want.entry_valid) begin
            $error("entry_valid: expected %0d, actual %0d", want.entry_valid, i_out_user);
            errors++;
        end
        if (got_low !== want.lowest) begin
            $error("lowest_value: expected %0d, actual %0d", want.lowest, got_low);
            errors++;
        end
        if (got_high !== want.highest) begin
            $error("highest_value: expected %0d, actual %0d", want.highest, got_high);
            errors++;
        end
        if (got_range !== want.wide_range) begin
            $error("largest_range: expected %0d, actual %0d", want.wide_range, got_range);
            errors++;
        end
        if (i_out_last !== want.last_row) begin
            $error("last_result: expected %0d, actual %0d", want.last_row, i_out_last);
            errors++;
        end
    endfunction

    // Everything is sampled at the rising edge, results before new input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            spg_reg = SPG_RESET;
            wg_reg  = WG_RESET;
            clear_period();
            awaited_rows.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_row();
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_SAMPLES_PER_GROUP)
                    spg_reg = i_cfg_data[SPG_BITS-1:0];
                else if (i_cfg_index == REG_WINDOW_GROUPS)
                    wg_reg = i_cfg_data[WG_BITS-1:0];
            end
            if (i_in_valid && i_in_ready)
                account_reading(i_in_data[SBITS-1:0], i_in_last);
        end
        o_errors  <= errors;
        o_pending <= awaited_rows.size();
        o_reports <= reports;
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for the period extremes and window range core: makes reset, stimulus and
// random stalls, and gives the verdict. Depends on pewr_pkg and pewr_report_checker.
module tb_top;
    import pewr_pkg::*;

    localparam int IN_BITS = ((SAMPLE_BITS_DEF + 7) / 8) * 8;
    localparam int SBITS   = SAMPLE_BITS_DEF;
    // Longest walk after a word plus margin, waited before any register write.
    localparam int DRAIN_CYCLES = MAX_WINDOW_GROUPS_DEF + 16;
    // Sample words to send in total before the closing word.
    localparam int WORD_BUDGET = 130;

    // Register indexes that the block must ignore.
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_B = 2'd3;

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [IN_BITS-1:0]        s_tdata;
    logic                      s_tlast;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [OUT_TDATA_BITS-1:0] m_tdata;
    logic                      m_tuser;
    logic                      m_tlast;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    int fail_count;
    int rows_pending;
    int reports_seen;
    int words_sent = 0;
    int phases     = 0;
    bit calm       = 1'b0;

    period_extremes_and_window_range_core uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    pewr_report_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (s_tvalid),
        .i_in_ready  (s_tready),
        .i_in_data   (s_tdata),
        .i_in_last   (s_tlast),
        .i_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_out_data  (m_tdata),
        .i_out_user  (m_tuser),
        .i_out_last  (m_tlast),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (fail_count),
        .o_pending   (rows_pending),
        .o_reports   (reports_seen)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run, far above the slowest legal run.
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result sink: a random stall before each word, none in calm stretches.
    initial begin
        int n;
        m_tready <= 1'b0;
        forever begin
            n = calm ? 0 : $urandom_range(0, 3);
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    // Offers one reading after a random gap and holds it until taken.
    task automatic send_reading(input logic signed [SBITS-1:0] v, input logic period_end);
        int n;
        n = calm ? 0 : $urandom_range(0, 3);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_BITS-SBITS){1'b0}}, v};
        s_tlast  <= period_end;
        do @(posedge clk); while (!(s_tvalid && s_tready));
        words_sent++;
    endtask

    // Writes one register, then leaves the channel idle.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stops input, waits for every owed report word, then lets any window walk finish.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (rows_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Readings from -1600 to 1120, with the extremes and near-equal clusters for ties.
    function automatic logic signed [SBITS-1:0] random_reading();
        int v;
        case ($urandom_range(0, 9))
            0:       v = -1600;
            1:       v = 1120;
            2, 3:    v = int'($urandom_range(0, 8)) - 4;
            default: v = int'($urandom_range(0, 2720)) - 1600;
        endcase
        return v[SBITS-1:0];
    endfunction

    task automatic send_period(input int count, input bit close_period);
        for (int i = 0; i < count; i++)
            send_reading(random_reading(), close_period && (i == count - 1));
    endtask

    initial begin
        int spg_raw;
        int wg_raw;
        int spg_eff;
        int wg_eff;
        int len;
        int periods;
        bit close_period;

        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fewer readings than the list depth, the extreme readings and no full window.
        send_reading(12'sd1120, 1'b0);
        send_reading(-12'sd1600, 1'b0);
        send_reading(-12'sd1, 1'b1);
        settle();

        // One reading per minute, one-minute window and tied readings.
        write_reg(REG_SAMPLES_PER_GROUP, 5'd1);
        write_reg(REG_WINDOW_GROUPS, 5'd1);
        send_reading(12'sd5, 1'b0);
        send_reading(12'sd5, 1'b0);
        send_reading(12'sd5, 1'b0);
        send_reading(-12'sd3, 1'b0);
        send_reading(-12'sd3, 1'b0);
        send_reading(12'sd7, 1'b1);
        settle();

        // Zero in either register behaves as one.
        write_reg(REG_SAMPLES_PER_GROUP, 5'd0);
        write_reg(REG_WINDOW_GROUPS, 5'd0);
        send_reading(12'sd100, 1'b0);
        send_reading(-12'sd100, 1'b0);
        send_reading(12'sd40, 1'b1);
        settle();

        // Oversized minute length saturates; writes to unused indexes change nothing.
        write_reg(REG_SAMPLES_PER_GROUP, 5'd31);
        write_reg(REG_WINDOW_GROUPS, 5'd1);
        write_reg(REG_UNUSED_A, 5'd3);
        write_reg(REG_UNUSED_B, 5'd31);
        send_period(11, 1'b1);
        settle();

        // Random phases: full windows most of the time, some periods cut short so that
        // the next register setting lands in the middle of a minute.
        while (words_sent < WORD_BUDGET) begin
            case (phases)
                0:       begin spg_raw = 1;  wg_raw = 31; end
                1:       begin spg_raw = 8;  wg_raw = 1;  end
                2:       begin spg_raw = 2;  wg_raw = 16; end
                3:       begin spg_raw = 4;  wg_raw = 3;  end
                default: begin
                    spg_raw = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(0, 31);
                    wg_raw  = $urandom_range(0, 1) ? $urandom_range(1, 5) : $urandom_range(0, 31);
                end
            endcase
            spg_eff = spg_raw % 16;
            if (spg_eff == 0)
                spg_eff = 1;
            if (spg_eff > int'(SPG_MAX))
                spg_eff = int'(SPG_MAX);
            wg_eff = wg_raw;
            if (wg_eff == 0)
                wg_eff = 1;
            if (wg_eff > MAX_WINDOW_GROUPS_DEF)
                wg_eff = MAX_WINDOW_GROUPS_DEF;

            if ($urandom_range(0, 1)) begin
                write_reg(REG_SAMPLES_PER_GROUP, spg_raw[CFG_DATA_BITS-1:0]);
                write_reg(REG_WINDOW_GROUPS, wg_raw[CFG_DATA_BITS-1:0]);
            end else begin
                write_reg(REG_WINDOW_GROUPS, wg_raw[CFG_DATA_BITS-1:0]);
                write_reg(REG_SAMPLES_PER_GROUP, spg_raw[CFG_DATA_BITS-1:0]);
            end
            if ($urandom_range(0, 4) == 0)
                write_reg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B,
                          CFG_DATA_BITS'($urandom_range(0, 31)));

            calm    = ($urandom_range(0, 3) == 0);
            periods = $urandom_range(1, 3);
            for (int p = 0; p < periods; p++) begin
                len = spg_eff * wg_eff;
                if (len <= 36 && $urandom_range(0, 3) != 0)
                    len += $urandom_range(0, 2 * spg_eff);
                else
                    len = $urandom_range(1, 20);
                // Keep the total close to the word budget.
                if (words_sent + len > WORD_BUDGET)
                    len = (words_sent < WORD_BUDGET) ? WORD_BUDGET - words_sent : 1;
                close_period = !((p == periods - 1) && ($urandom_range(0, 3) == 0));
                send_period(len, close_period);
            end
            settle();
            phases++;
        end

        // Close whatever period is still open so that its report is checked too.
        send_reading(random_reading(), 1'b1);
        settle();

        $display("Run covered %0d sample words over %0d random register settings.",
                 words_sent, phases);
        $display("%0d reports predicted and compared word by word.", reports_seen);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
